FILE: sv/hash_chain_match_finder_macros.svh
// assertion macros shared by the checker
`ifndef HASH_CHAIN_MATCH_FINDER_MACROS_SVH
`define HASH_CHAIN_MATCH_FINDER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define HCMF_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash chain match finder check failed");

// next-cycle implication, sampled on clk, off while in reset
`define HCMF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash chain match finder check failed");

`endif

FILE: sv/hcmf_pkg.sv
package hcmf_pkg;

    // default sizes
    localparam int DICT_SIZE_DEF   = 4096;
    localparam int HASH_SIZE_DEF   = 8192;
    localparam int TARGET_SIZE_DEF = 4096;

    localparam int PREFIX_BYTES = 4;
    localparam int WORD_W       = 8 * PREFIX_BYTES;
    localparam int MAX_LEN      = 255;
    localparam int MAX_DISTANCE = 65535;

    // field widths
    localparam int KIND_W     = 2;
    localparam int POS_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int OFF_W      = 12;
    localparam int TLEN_W     = 13;
    localparam int LEN_W      = 8;
    localparam int DLEN_W     = 13;
    localparam int MOD_W      = 14;
    localparam int ITER_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [KIND_W-1:0] {
        KIND_DICT_WRITE = 2'd0,
        KIND_INSERT     = 2'd1,
        KIND_TGT_WRITE  = 2'd2,
        KIND_QUERY      = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DICT_LENGTH  = 2'd0,
        CFG_HASH_MODULUS = 2'd1,
        CFG_ITER_LIMIT   = 2'd2,
        CFG_SAME_BUFFER  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        kind_t               kind;
        logic [POS_W-1:0]    position;
        logic [BYTE_W-1:0]   byte_value;
        logic [OFF_W-1:0]    target_offset;
        logic [TLEN_W-1:0]   target_length;
    } item_t;

    // front queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } fq_t;

    // back end control toward the front
    typedef struct packed {
        logic take;
        logic clearing;
    } back_ctl_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WADDR,
        S_WDATA,
        S_MOD,
        S_MODW,
        S_HRD,
        S_HUSE,
        S_CAND,
        S_BADDR,
        S_BCMP,
        S_NEXT,
        S_LUSE,
        S_RESULT
    } state_t;

endpackage

FILE: sv/hcmf_ram.sv
module hcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/hcmf_front.sv
module hcmf_front import hcmf_pkg::*; #(
    parameter int DICT_SIZE   = DICT_SIZE_DEF,
    parameter int TARGET_SIZE = TARGET_SIZE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [KIND_W-1:0] kind,
    input  logic [POS_W-1:0]  position,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic [OFF_W-1:0]  target_offset,
    input  logic [TLEN_W-1:0] target_length,
    input  back_ctl_t         ctl,
    output fq_t               fq
);

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       drop;
    logic       keep;
    logic       take;
    item_t      item_in;

    assign item_in.kind          = kind_t'(kind);
    assign item_in.position      = position;
    assign item_in.byte_value    = byte_value;
    assign item_in.target_offset = target_offset;
    assign item_in.target_length = target_length;

    // writes and inserts past the store are dropped here
    always_comb
    begin
        unique case (item_in.kind)
            KIND_DICT_WRITE: drop = (32'(position) >= DICT_SIZE);
            KIND_INSERT:     drop = (32'(position) >= DICT_SIZE);
            KIND_TGT_WRITE:  drop = (32'(position) >= TARGET_SIZE);
            KIND_QUERY:      drop = 1'b0;
            default:         drop = 1'b0;
        endcase
    end

    assign full = (cnt_reg == 2'd2) || ctl.clearing;
    assign keep = push && !full && !drop;
    assign take = ctl.take && (cnt_reg != 2'd0);

    assign fq.valid = (cnt_reg != 2'd0);
    assign fq.item  = q_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ keep;
        rd_ptr_next = rd_ptr_reg ^ take;
        cnt_next    = cnt_reg + {1'b0, keep} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue slots
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

FILE: sv/hcmf_mod.sv
module hcmf_mod import hcmf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [MOD_W-1:0]  divisor,
    output logic              done,
    output logic [MOD_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [MOD_W-1:0]  dvs_reg, dvs_next;
    logic [MOD_W-1:0]  rem_reg, rem_next;
    logic [MOD_W:0]    trial;

    assign trial     = {rem_reg, dvd_reg[WORD_W-1]};
    assign done      = done_reg;
    assign remainder = rem_reg;

    // restoring remainder, one dividend bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = MOD_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[MOD_W-1:0];
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

endmodule

FILE: sv/hcmf_back.sv
module hcmf_back import hcmf_pkg::*; #(
    parameter int DICT_SIZE   = DICT_SIZE_DEF,
    parameter int HASH_SIZE   = HASH_SIZE_DEF,
    parameter int TARGET_SIZE = TARGET_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  fq_t                   fq,
    output back_ctl_t             ctl,
    output logic                  out_vld,
    input  logic                  out_pop,
    output logic [POS_W-1:0]      match_offset,
    output logic [LEN_W-1:0]      match_length
);

    localparam int DAW  = $clog2(DICT_SIZE);
    localparam int TAW  = $clog2(TARGET_SIZE);
    localparam int HW   = $clog2(HASH_SIZE);
    localparam int SW   = POS_W + 1;
    localparam int VW   = $clog2(DICT_SIZE) + 1;
    localparam int CW   = (VW > ITER_W + 1) ? VW : ITER_W + 1;
    localparam int ENDW = 15;
    localparam int DSTW = 18;

    // configuration
    logic [DLEN_W-1:0] dict_length_reg;
    logic [MOD_W-1:0]  hash_modulus_reg;
    logic [ITER_W-1:0] iter_limit_reg;
    logic              same_buffer_reg;

    state_t               state_reg, state_next;
    kind_t                op_reg, op_next;
    logic [POS_W-1:0]     base_reg, base_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [HW-1:0]        h_reg, h_next;
    logic                 have_reg, have_next;
    logic [POS_W-1:0]     cand_reg, cand_next;
    logic [VW-1:0]        visited_reg, visited_next;
    logic [LEN_W-1:0]     j_reg, j_next;
    logic signed [ENDW-1:0] lim_reg, lim_next;
    logic signed [ENDW-1:0] end_reg, end_next;
    logic [LEN_W-1:0]     best_len_reg, best_len_next;
    logic [POS_W-1:0]     best_off_reg, best_off_next;
    logic [HW-1:0]        clr_reg, clr_next;
    logic                 out_vld_reg, out_vld_next;
    logic [POS_W-1:0]     out_off_reg, out_off_next;
    logic [LEN_W-1:0]     out_len_reg, out_len_next;
    logic                 t_oob_reg, d_oob_reg;

    // derived values
    logic [DLEN_W-1:0]      dlen;
    logic [MOD_W-1:0]       modulus;
    logic [SW-1:0]          t_sum, d_sum;
    logic [BYTE_W-1:0]      t_byte, d_byte;
    logic signed [ENDW-1:0] lim_raw, rest;
    logic signed [DSTW-1:0] cand_dist;
    logic                   j_lt_end;
    logic                   finish;
    logic                   take;
    logic                   div_start, div_done;
    logic [MOD_W-1:0]       div_rem;

    // memory ports
    logic              dict_we, tgt_we, head_we, link_we;
    logic [BYTE_W-1:0] dict_a_rdata, dict_b_rdata, tgt_rdata;
    logic [POS_W:0]    head_wdata, head_rdata, link_rdata;
    logic [HW-1:0]     head_waddr;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dict_length_reg  <= '0;
            hash_modulus_reg <= MOD_W'(7168);
            iter_limit_reg   <= ITER_W'(64);
            same_buffer_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DICT_LENGTH:  dict_length_reg  <= cfg_data[DLEN_W-1:0];
                CFG_HASH_MODULUS: hash_modulus_reg <= cfg_data[MOD_W-1:0];
                CFG_ITER_LIMIT:   iter_limit_reg   <= cfg_data[ITER_W-1:0];
                CFG_SAME_BUFFER:  same_buffer_reg  <= cfg_data[0];
                default:          same_buffer_reg  <= same_buffer_reg;
            endcase
        end
    end

    // clamped dictionary length and modulus
    assign dlen = (32'(dict_length_reg) > DICT_SIZE) ? DLEN_W'(DICT_SIZE)
                                                      : dict_length_reg;
    always_comb
    begin
        if (hash_modulus_reg == '0)
        begin
            modulus = MOD_W'(1);
        end
        else if (32'(hash_modulus_reg) > HASH_SIZE)
        begin
            modulus = MOD_W'(HASH_SIZE);
        end
        else
        begin
            modulus = hash_modulus_reg;
        end
    end

    // byte addresses on the target side and the dictionary side
    assign t_sum = SW'(base_reg) + SW'(j_reg);
    assign d_sum = ((op_reg == KIND_QUERY) ? SW'(cand_reg) : SW'(base_reg)) + SW'(j_reg);

    always_ff @(posedge clk)
    begin
        t_oob_reg <= same_buffer_reg ? (32'(t_sum) >= DICT_SIZE)
                                     : (32'(t_sum) >= TARGET_SIZE);
        d_oob_reg <= (32'(d_sum) >= DICT_SIZE);
    end

    assign t_byte = t_oob_reg ? '0 : (same_buffer_reg ? dict_a_rdata : tgt_rdata);
    assign d_byte = d_oob_reg ? '0 : dict_b_rdata;

    // bounds for the current query and candidate
    assign lim_raw = $signed({2'b00, fq.item.target_length})
                   - $signed({3'b000, fq.item.target_offset});
    assign rest    = $signed({2'b00, dlen}) - $signed({3'b000, cand_reg});
    assign cand_dist = same_buffer_reg
                     ? ($signed({6'b0, base_reg}) - $signed({6'b0, cand_reg}))
                     : ($signed({5'b0, dlen}) - $signed({6'b0, cand_reg})
                        + $signed({6'b0, base_reg}));
    assign j_lt_end = $signed({7'b0, j_reg}) < end_reg;

    assign ctl.clearing = (state_reg == S_CLEAR);
    assign ctl.take     = take;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        base_next     = base_reg;
        word_next     = word_reg;
        h_next        = h_reg;
        have_next     = have_reg;
        cand_next     = cand_reg;
        visited_next  = visited_reg;
        j_next        = j_reg;
        lim_next      = lim_reg;
        end_next      = end_reg;
        best_len_next = best_len_reg;
        best_off_next = best_off_reg;
        clr_next      = clr_reg;
        out_vld_next  = out_vld_reg && !out_pop;
        out_off_next  = out_off_reg;
        out_len_next  = out_len_reg;
        take          = 1'b0;
        dict_we       = 1'b0;
        tgt_we        = 1'b0;
        head_we       = 1'b0;
        link_we       = 1'b0;
        div_start     = 1'b0;
        finish        = 1'b0;

        unique case (state_reg)
            // clear the head table after reset
            S_CLEAR:
            begin
                head_we  = 1'b1;
                clr_next = clr_reg + HW'(1);
                if (32'(clr_reg) == HASH_SIZE - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            // take the next queued item
            S_IDLE:
            begin
                if (fq.valid)
                begin
                    take    = 1'b1;
                    op_next = fq.item.kind;
                    j_next  = '0;
                    unique case (fq.item.kind)
                        KIND_DICT_WRITE: dict_we = 1'b1;
                        KIND_TGT_WRITE:  tgt_we  = 1'b1;
                        KIND_INSERT:
                        begin
                            base_next  = fq.item.position;
                            state_next = S_WADDR;
                        end
                        KIND_QUERY:
                        begin
                            base_next     = fq.item.target_offset;
                            lim_next      = (lim_raw > ENDW'(MAX_LEN)) ? ENDW'(MAX_LEN)
                                                                       : lim_raw;
                            best_len_next = '0;
                            best_off_next = '0;
                            state_next    = (dlen == '0) ? S_RESULT : S_WADDR;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            // gather the little-endian prefix word
            S_WADDR: state_next = S_WDATA;
            S_WDATA:
            begin
                word_next = {((op_reg == KIND_QUERY) ? t_byte : d_byte),
                             word_reg[WORD_W-1:BYTE_W]};
                j_next    = j_reg + LEN_W'(1);
                state_next = (j_reg == LEN_W'(PREFIX_BYTES - 1)) ? S_MOD : S_WADDR;
            end
            S_MOD:
            begin
                div_start  = 1'b1;
                state_next = S_MODW;
            end
            S_MODW:
            begin
                if (div_done)
                begin
                    h_next     = HW'(div_rem);
                    state_next = S_HRD;
                end
            end
            S_HRD: state_next = S_HUSE;
            // insert links to the old head, or the walk starts there
            S_HUSE:
            begin
                if (op_reg == KIND_INSERT)
                begin
                    link_we    = 1'b1;
                    head_we    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    have_next    = head_rdata[POS_W];
                    cand_next    = head_rdata[POS_W-1:0];
                    visited_next = '0;
                    state_next   = S_CAND;
                end
            end
            // candidate checks before comparing bytes
            S_CAND:
            begin
                if (!have_reg || 32'(visited_reg) >= DICT_SIZE
                    || cand_dist > DSTW'(MAX_DISTANCE))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    end_next   = (lim_reg < rest) ? lim_reg : rest;
                    j_next     = '0;
                    state_next = S_BADDR;
                end
            end
            S_BADDR:
            begin
                if (j_reg >= LEN_W'(PREFIX_BYTES) && !j_lt_end)
                begin
                    finish     = 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    state_next = S_BCMP;
                end
            end
            S_BCMP:
            begin
                if (t_byte == d_byte)
                begin
                    j_next     = j_reg + LEN_W'(1);
                    state_next = S_BADDR;
                end
                else
                begin
                    finish     = (j_reg >= LEN_W'(PREFIX_BYTES));
                    state_next = S_NEXT;
                end
            end
            // follow the chain link
            S_NEXT:
            begin
                visited_next = visited_reg + VW'(1);
                state_next   = S_LUSE;
            end
            S_LUSE:
            begin
                have_next = link_rdata[POS_W];
                cand_next = link_rdata[POS_W-1:0];
                if (iter_limit_reg != '0
                    && CW'(visited_reg) > CW'(iter_limit_reg) + CW'(1))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_CAND;
                end
            end
            // hand the result to the output register
            S_RESULT:
            begin
                if (!out_vld_reg || out_pop)
                begin
                    out_vld_next = 1'b1;
                    out_off_next = best_off_reg;
                    out_len_next = best_len_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // longest wins, nearest on ties
        if (finish && j_reg > best_len_reg)
        begin
            best_len_next = j_reg;
            best_off_next = cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        base_reg     <= base_next;
        word_reg     <= word_next;
        h_reg        <= h_next;
        have_reg     <= have_next;
        cand_reg     <= cand_next;
        visited_reg  <= visited_next;
        j_reg        <= j_next;
        lim_reg      <= lim_next;
        end_reg      <= end_next;
        best_len_reg <= best_len_next;
        best_off_reg <= best_off_next;
        out_off_reg  <= out_off_next;
        out_len_reg  <= out_len_next;
    end

    assign out_vld      = out_vld_reg;
    assign match_offset = out_off_reg;
    assign match_length = out_len_reg;

    // hash unit
    hcmf_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (word_reg),
        .divisor   (modulus),
        .done      (div_done),
        .remainder (div_rem)
    );

    // dictionary, two copies for two read ports
    hcmf_ram #(.WIDTH(BYTE_W), .DEPTH(DICT_SIZE)) u_dict_a (
        .clk   (clk),
        .we    (dict_we),
        .waddr (DAW'(fq.item.position)),
        .wdata (fq.item.byte_value),
        .raddr (DAW'(t_sum)),
        .rdata (dict_a_rdata)
    );

    hcmf_ram #(.WIDTH(BYTE_W), .DEPTH(DICT_SIZE)) u_dict_b (
        .clk   (clk),
        .we    (dict_we),
        .waddr (DAW'(fq.item.position)),
        .wdata (fq.item.byte_value),
        .raddr (DAW'(d_sum)),
        .rdata (dict_b_rdata)
    );

    hcmf_ram #(.WIDTH(BYTE_W), .DEPTH(TARGET_SIZE)) u_tgt (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (TAW'(fq.item.position)),
        .wdata (fq.item.byte_value),
        .raddr (TAW'(t_sum)),
        .rdata (tgt_rdata)
    );

    // head table entries carry a valid bit on top
    assign head_waddr = ctl.clearing ? clr_reg : h_reg;
    assign head_wdata = ctl.clearing ? '0 : {1'b1, base_reg};

    hcmf_ram #(.WIDTH(POS_W + 1), .DEPTH(HASH_SIZE)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (h_reg),
        .rdata (head_rdata)
    );

    hcmf_ram #(.WIDTH(POS_W + 1), .DEPTH(DICT_SIZE)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (DAW'(base_reg)),
        .wdata (head_rdata),
        .raddr (DAW'(cand_reg)),
        .rdata (link_rdata)
    );

endmodule

FILE: sv/hash_chain_match_finder.sv
// LZ77 hash-chain match finder. Items enter through a two-entry queue (push/full) and are
// carried out one at a time by a sequencer; query results leave through a one-entry output
// register (empty/pop). After reset the head table is cleared, one entry a cycle, all
// HASH_SIZE entries (8192 by default), with full held high; configuration writes are taken
// during that time. A byte write is done as it is taken from the queue. An insert is taken,
// reads the 4-byte word, hashes it in the bit-serial modulo unit, then reads and updates
// the head. A query hashes its word the same way, then per visited candidate does chain
// bookkeeping and compares byte by byte (up to 255 bytes), and then hands over the result,
// so its time is set by the chain length, the iteration limit, the match lengths met on
// the way and how soon the previous result is popped.
module hash_chain_match_finder import hcmf_pkg::*; #(
    parameter int DICT_SIZE   = DICT_SIZE_DEF,
    parameter int HASH_SIZE   = HASH_SIZE_DEF,
    parameter int TARGET_SIZE = TARGET_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [KIND_W-1:0]     kind,
    input  logic [POS_W-1:0]      position,
    input  logic [BYTE_W-1:0]     byte_value,
    input  logic [OFF_W-1:0]      target_offset,
    input  logic [TLEN_W-1:0]     target_length,
    output logic                  empty,
    input  logic                  pop,
    output logic [POS_W-1:0]      match_offset,
    output logic [LEN_W-1:0]      match_length,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fq_t       fq;
    back_ctl_t ctl;
    logic      out_vld;

    // accept and classify
    hcmf_front #(.DICT_SIZE(DICT_SIZE), .TARGET_SIZE(TARGET_SIZE)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .kind          (kind),
        .position      (position),
        .byte_value    (byte_value),
        .target_offset (target_offset),
        .target_length (target_length),
        .ctl           (ctl),
        .fq            (fq)
    );

    // execute
    hcmf_back #(
        .DICT_SIZE   (DICT_SIZE),
        .HASH_SIZE   (HASH_SIZE),
        .TARGET_SIZE (TARGET_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fq           (fq),
        .ctl          (ctl),
        .out_vld      (out_vld),
        .out_pop      (pop),
        .match_offset (match_offset),
        .match_length (match_length)
    );

    assign empty = !out_vld;

endmodule

FILE: sv/hcmf_checker.sv
`include "hash_chain_match_finder_macros.svh"

module hcmf_checker import hcmf_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input logic                  full,
    input logic [KIND_W-1:0]     kind,
    input logic [POS_W-1:0]      position,
    input logic [BYTE_W-1:0]     byte_value,
    input logic [OFF_W-1:0]      target_offset,
    input logic [TLEN_W-1:0]     target_length,
    input logic                  empty,
    input logic                  pop,
    input logic [POS_W-1:0]      match_offset,
    input logic [LEN_W-1:0]      match_length,
    input logic                  cfg_write,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    logic [2:0] pend_reg, pend_next;
    logic       q_in, q_out;

    // queries accepted but whose result was not yet transferred
    assign q_in  = push && !full && (kind_t'(kind) == KIND_QUERY);
    assign q_out = pop && !empty;

    always_comb
    begin
        pend_next = pend_reg + {2'b00, q_in} - {2'b00, q_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `HCMF_ASSERT_IMPLY(a_result_has_query, !empty, pend_reg != 3'd0)
    `HCMF_ASSERT_IMPLY(a_no_match_zero_offset, !empty && match_length == '0, match_offset == '0)
    `HCMF_ASSERT_IMPLY(a_min_length, !empty, match_length == '0 || match_length >= 8'd4)
    `HCMF_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(match_offset) && $stable(match_length))

endmodule

bind hash_chain_match_finder hcmf_checker u_hcmf_checker (.*);

FILE: tb/hash_chain_match_finder_tb.sv
`timescale 1ns / 100ps

module hash_chain_match_finder_tb import hcmf_pkg::*;;

    localparam int DSIZE       = 4096;
    localparam int HSIZE       = 8192;
    localparam int TSIZE       = 4096;
    localparam int CYCLE_LIMIT = 40000000;
    localparam int SETTLE      = 200;

    typedef struct packed {
        logic [POS_W-1:0] off;
        logic [LEN_W-1:0] len;
    } match_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [KIND_W-1:0]     kind = '0;
    logic [POS_W-1:0]      position = '0;
    logic [BYTE_W-1:0]     byte_value = '0;
    logic [OFF_W-1:0]      target_offset = '0;
    logic [TLEN_W-1:0]     target_length = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [POS_W-1:0]      match_offset;
    logic [LEN_W-1:0]      match_length;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    hash_chain_match_finder dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .position(position), .byte_value(byte_value), .target_offset(target_offset),
        .target_length(target_length), .empty(empty), .pop(pop),
        .match_offset(match_offset), .match_length(match_length),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // finder state mirrored in the testbench
    logic [7:0] dict_mem [DSIZE];
    logic [7:0] tgt_mem [TSIZE];
    bit         dict_set [DSIZE];
    bit         tgt_set [TSIZE];
    int         head_pos [HSIZE];
    bit         head_ok [HSIZE];
    int         link_pos [DSIZE];
    bit         link_ok [DSIZE];
    int         cfg_dlen = 0;
    int         cfg_mod = 7168;
    int         cfg_iter = 64;
    bit         cfg_same = 1'b0;
    bit         read_gap;

    match_t     expected_matches[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         items_sent = 0;
    int         matches_seen = 0;
    int         settings_used = 0;
    int         mismatches = 0;
    int         cycles = 0;
    int         dict_base = 64;

    // clock and watchdog
    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("hash_chain_match_finder regression: fail");
            $finish;
        end
    end

    // byte reads, flagging any byte that was never written
    function automatic logic [7:0] dict_rd(int a);
        if (a < 0 || a >= DSIZE)
            return 8'd0;
        if (!dict_set[a])
            read_gap = 1'b1;
        return dict_mem[a];
    endfunction

    function automatic logic [7:0] src_rd(int a);
        if (cfg_same)
            return dict_rd(a);
        if (a < 0 || a >= TSIZE)
            return 8'd0;
        if (!tgt_set[a])
            read_gap = 1'b1;
        return tgt_mem[a];
    endfunction

    function automatic bit [31:0] dict_word(int a);
        return {dict_rd(a + 3), dict_rd(a + 2), dict_rd(a + 1), dict_rd(a)};
    endfunction

    function automatic bit [31:0] src_word(int a);
        return {src_rd(a + 3), src_rd(a + 2), src_rd(a + 1), src_rd(a)};
    endfunction

    function automatic int head_slot(bit [31:0] w);
        bit [31:0] m;
        m = cfg_mod;
        if (m < 1)
            m = 1;
        if (m > HSIZE)
            m = HSIZE;
        return int'(w % m);
    endfunction

    // apply one item to the mirror; 0 means it would touch unwritten bytes
    function automatic bit update_finder(item_t it);
        int      dlen, lim, toff, tlen, cand, cand_dist, endv, j, best_off, best_len, visited, h;
        bit [31:0] tw;
        bit      have;
        match_t  res;
        read_gap = 1'b0;
        case (it.kind)
            KIND_DICT_WRITE:
            begin
                dict_mem[it.position] = it.byte_value;
                dict_set[it.position] = 1'b1;
                return 1'b1;
            end
            KIND_TGT_WRITE:
            begin
                tgt_mem[it.position] = it.byte_value;
                tgt_set[it.position] = 1'b1;
                return 1'b1;
            end
            KIND_INSERT:
            begin
                tw = dict_word(it.position);
                if (read_gap)
                    return 1'b0;
                h = head_slot(tw);
                link_pos[it.position] = head_pos[h];
                link_ok[it.position] = head_ok[h];
                head_pos[h] = it.position;
                head_ok[h] = 1'b1;
                return 1'b1;
            end
            default:
            begin
                best_off = 0;
                best_len = 0;
                dlen = (cfg_dlen > DSIZE) ? DSIZE : cfg_dlen;
                toff = it.target_offset;
                tlen = it.target_length;
                if (dlen != 0)
                begin
                    lim = tlen - toff;
                    if (lim > MAX_LEN)
                        lim = MAX_LEN;
                    tw = src_word(toff);
                    h = head_slot(tw);
                    have = head_ok[h];
                    cand = head_pos[h];
                    visited = 0;
                    // walk nearest to farthest
                    while (have && visited < DSIZE)
                    begin
                        cand_dist = cfg_same ? (toff - cand) : (dlen - cand + toff);
                        if (cand_dist > MAX_DISTANCE)
                            break;
                        if (tw == dict_word(cand))
                        begin
                            endv = (lim < dlen - cand) ? lim : dlen - cand;
                            j = PREFIX_BYTES;
                            while (j < endv && src_rd(toff + j) == dict_rd(cand + j))
                                j++;
                            if (j > best_len)
                            begin
                                best_len = j;
                                best_off = cand;
                            end
                        end
                        visited++;
                        have = link_ok[cand];
                        cand = link_pos[cand];
                        if (cfg_iter != 0 && visited > cfg_iter + 1)
                            break;
                    end
                end
                if (read_gap)
                    return 1'b0;
                res.off = best_off[POS_W-1:0];
                res.len = best_len[LEN_W-1:0];
                expected_matches.push_back(res);
                return 1'b1;
            end
        endcase
    endfunction

    // one input transfer, skipped if it would read unwritten bytes
    task automatic send_item(kind_t k, int pos, int bv, int toff, int tlen);
        item_t it;
        it.kind = k;
        it.position = pos[POS_W-1:0];
        it.byte_value = bv[BYTE_W-1:0];
        it.target_offset = toff[OFF_W-1:0];
        it.target_length = tlen[TLEN_W-1:0];
        if (!update_finder(it))
            return;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        kind <= it.kind;
        position <= it.position;
        byte_value <= it.byte_value;
        target_offset <= it.target_offset;
        target_length <= it.target_length;
        @(negedge clk);
        while (full)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    // hold off until every result is back and the sequencer has settled
    task automatic drain();
        push <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(int dlen, int modv, int iter, bit same);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_DICT_LENGTH;
        cfg_data <= dlen[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_HASH_MODULUS;
        cfg_data <= modv[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_ITER_LIMIT;
        cfg_data <= iter[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_SAME_BUFFER;
        cfg_data <= {{(CFG_DATA_W-1){1'b0}}, same};
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_dlen = dlen & 32'h1FFF;
        cfg_mod = modv & 32'h3FFF;
        cfg_iter = iter & 32'h7FF;
        cfg_same = same;
        settings_used++;
    endtask

    function automatic int pick_byte();
        return ($urandom_range(3) == 0) ? $urandom_range(255) : 8'h61 + $urandom_range(2);
    endfunction

    // stray writes and queries with random fields
    task automatic send_noise();
        kind_t k;
        case ($urandom_range(2))
            0: k = KIND_DICT_WRITE;
            1: k = KIND_TGT_WRITE;
            default: k = KIND_QUERY;
        endcase
        send_item(k, $urandom_range(4095), $urandom_range(255), $urandom_range(4095),
                  $urandom_range(8191));
    endtask

    // result transfers: sampled between edges, accepted at the next rising edge
    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    always @(negedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            matches_seen++;
            if (expected_matches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected match: offset %0d length %0d",
                             match_offset, match_length);
            end
            else
            begin
                match_t e;
                e = expected_matches.pop_front();
                if (e.off !== match_offset || e.len !== match_length)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("match mismatch: expected offset %0d length %0d, got %0d %0d",
                                 e.off, e.len, match_offset, match_length);
                end
            end
        end
    end

    // overlapping words, ties, short bounds, missing word
    task automatic test_basic_match();
        int pat [12] = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h41, 8'h42, 8'h43, 8'h44,
                         8'h41, 8'h42, 8'h43, 8'h45};
        configure(12, 8192, 0, 1'b0);
        for (int i = 0; i < 12; i++)
            send_item(KIND_DICT_WRITE, i, pat[i], 0, 0);
        send_item(KIND_INSERT, 0, 0, 0, 0);
        send_item(KIND_INSERT, 4, 0, 0, 0);
        send_item(KIND_INSERT, 8, 0, 0, 0);
        for (int i = 0; i < 8; i++)
            send_item(KIND_TGT_WRITE, i, pat[i], 0, 0);
        send_item(KIND_QUERY, 0, 0, 0, 8);
        send_item(KIND_QUERY, 0, 0, 0, 2);
        send_item(KIND_QUERY, 0, 0, 4, 8);
        send_item(KIND_QUERY, 0, 0, 1, 8);
    endtask

    // empty dictionary, clamped registers, field extremes, same-buffer reads
    task automatic test_limits();
        configure(0, 8192, 64, 1'b0);
        send_item(KIND_QUERY, 0, 0, 0, 8);
        configure(8191, 0, 2047, 1'b0);
        send_item(KIND_INSERT, 0, 0, 0, 0);
        send_item(KIND_QUERY, 0, 0, 0, 4);
        send_item(KIND_DICT_WRITE, 4095, 255, 0, 0);
        send_item(KIND_TGT_WRITE, 4095, 255, 0, 0);
        send_item(KIND_QUERY, 0, 0, 4095, 8191);
        configure(4096, 16383, 1, 1'b1);
        send_item(KIND_QUERY, 0, 0, 8, 12);
        send_item(KIND_QUERY, 0, 0, 4, 12);
        send_item(KIND_QUERY, 0, 0, 0, 12);
        configure(12, 8192, 1024, 1'b1);
        send_item(KIND_QUERY, 0, 0, 0, 12);
    endtask

    // rounds of fill, insert, target and query on fresh dictionary ranges
    task automatic test_random(int n_items, int s_pct, int r_pct);
        int start, d, t, q, src, modv, iter, toff, tlen;
        bit same;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            d = ($urandom_range(9) == 0) ? $urandom_range(100, 200) : $urandom_range(8, 40);
            if (dict_base + d + 8 > 3990)
                dict_base = 64;
            case ($urandom_range(5))
                0: modv = 1;
                1: modv = $urandom_range(2, 64);
                2: modv = 7168;
                3: modv = 8192;
                4: modv = $urandom_range(1, 16383);
                default: modv = 0;
            endcase
            case ($urandom_range(3))
                0: iter = 0;
                1: iter = $urandom_range(1, 4);
                default: iter = $urandom_range(1, 2047);
            endcase
            if (modv < 16 && iter == 0)
                iter = $urandom_range(1, 64);
            same = $urandom_range(1);
            configure(dict_base + d, modv, iter, same);
            for (int i = 0; i < d + 4; i++)
            begin
                if ($urandom_range(11) == 0)
                    send_noise();
                send_item(KIND_DICT_WRITE, dict_base + i, pick_byte(), $urandom_range(4095),
                          $urandom_range(8191));
            end
            for (int i = 0; i < d; i++)
                send_item(KIND_INSERT, dict_base + i, $urandom_range(255),
                          $urandom_range(4095), $urandom_range(8191));
            if (same)
            begin
                q = d / 2 + 2;
                for (int i = 0; i < q; i++)
                begin
                    toff = dict_base + $urandom_range(d - 1);
                    tlen = ($urandom_range(7) == 0) ? $urandom_range(8191) : dict_base + d;
                    send_item(KIND_QUERY, $urandom_range(4095), $urandom_range(255), toff, tlen);
                end
            end
            else
            begin
                t = $urandom_range(6, 40);
                src = dict_base + $urandom_range(d - 1);
                for (int i = 0; i < t + 4; i++)
                    send_item(KIND_TGT_WRITE, i,
                              ($urandom_range(7) == 0 || src + i >= dict_base + d + 4) ?
                              pick_byte() : int'(dict_mem[src + i]),
                              $urandom_range(4095), $urandom_range(8191));
                q = t / 2 + 2;
                for (int i = 0; i < q; i++)
                begin
                    if ($urandom_range(11) == 0)
                        send_noise();
                    toff = $urandom_range(t - 1);
                    tlen = ($urandom_range(7) == 0) ? $urandom_range(8191) : t + 4;
                    send_item(KIND_QUERY, $urandom_range(4095), $urandom_range(255), toff, tlen);
                end
            end
            dict_base += d + 4;
        end
        send_idle_pct = 0;
    endtask

    // re-inserting a position closes its chain on itself
    task automatic test_chain_loop();
        configure(4004, 8192, 3, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            send_item(KIND_DICT_WRITE, 4000 + i, 8'hEE, 0, 0);
            send_item(KIND_TGT_WRITE, i, 8'hEE, 0, 0);
        end
        send_item(KIND_INSERT, 4000, 0, 0, 0);
        send_item(KIND_INSERT, 4000, 0, 0, 0);
        send_item(KIND_QUERY, 0, 0, 0, 4);
        configure(4004, 8192, 0, 1'b0);
        send_item(KIND_QUERY, 0, 0, 0, 4);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_match();
        test_limits();
        test_random(620, 16, 55);
        test_random(620, 55, 16);
        test_random(620, 0, 0);
        test_chain_loop();
        drain();
        if (expected_matches.size() != 0)
            mismatches++;
        $display("covered %0d items and %0d checked matches over %0d register settings",
                 items_sent, matches_seen, settings_used);
        $display("including same-buffer walks, clamped registers and a looped chain");
        if (mismatches == 0)
            $display("hash_chain_match_finder regression: pass");
        else
            $display("hash_chain_match_finder regression: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/hcmf_pkg.sv
sv/hcmf_ram.sv
sv/hcmf_front.sv
sv/hcmf_mod.sv
sv/hcmf_back.sv
sv/hash_chain_match_finder.sv
sv/hcmf_checker.sv
tb/hash_chain_match_finder_tb.sv
